FILE: hdl/ile_pkg.sv
// Shared types and codes for the indexed list engine.
// No dependencies; every other file in hdl/ imports this package.
package ile_pkg;

    localparam int MODE_BITS   = 3;
    localparam int POS_BITS    = 7;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 3;
    localparam int CFG_BITS    = 7;

    // Operation codes carried in the mode field
    localparam logic [MODE_BITS-1:0] MODE_INSERT     = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_READ_AT    = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_FIND       = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE_VAL = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE_AT  = 3'd4;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd4;

    // Per-cell update command
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_LOAD,
        CMD_TAKE_LEFT,
        CMD_TAKE_RIGHT
    } cell_cmd_t;

    // What each cell compares against when a word is accepted
    typedef struct packed {
        logic                by_value;
        logic [POS_BITS-1:0] position;
    } probe_t;

endpackage

FILE: hdl/ile_ifs.sv
// Valid/ready channel interfaces for the list engine request and response words.
// Depends on ile_pkg for field widths.
interface ile_req_if;
    import ile_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [MODE_BITS-1:0]  mode;
    logic [POS_BITS-1:0]   position;
    logic [VALUE_BITS-1:0] element;

    modport source (output valid, output mode, output position, output element, input ready);
    modport sink   (input valid, input mode, input position, input element, output ready);
endinterface

interface ile_rsp_if;
    import ile_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [VALUE_BITS-1:0]  value_out;
    logic [POS_BITS-1:0]    position_out;
    logic [POS_BITS-1:0]    count_out;

    modport source (output valid, output status, output value_out, output position_out,
                    output count_out, input ready);
    modport sink   (input valid, input status, input value_out, input position_out,
                    input count_out, output ready);
endinterface

FILE: hdl/ile_cell.sv
// One list slot: holds an entry, compares it on request, shifts with its neighbors.
// Depends on ile_pkg.
module ile_cell #(
    parameter int IDX          = 0,
    parameter int ELEMENT_BITS = 32,
    parameter int CW           = 7
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    capture,
    input  ile_pkg::probe_t         probe,
    input  logic [ELEMENT_BITS-1:0] elem,
    input  logic [CW-1:0]           count,
    input  ile_pkg::cell_cmd_t      cmd,
    input  logic [ELEMENT_BITS-1:0] left_value,
    input  logic [ELEMENT_BITS-1:0] right_value,
    output logic [ELEMENT_BITS-1:0] value,
    output logic                    hit
);
    import ile_pkg::*;

    localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

    logic [ELEMENT_BITS-1:0] value_reg;
    logic                    hit_reg;
    logic                    hit_next;

    always_comb
    begin
        if (probe.by_value)
            hit_next = (value_reg == elem) && (CW'(IDX) < count);
        else
            hit_next = (PW'(IDX) == PW'(probe.position));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (capture)
            hit_reg <= hit_next;
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_HOLD:       value_reg <= value_reg;
            CMD_LOAD:       value_reg <= elem;
            CMD_TAKE_LEFT:  value_reg <= left_value;
            CMD_TAKE_RIGHT: value_reg <= right_value;
            default:        value_reg <= value_reg;
        endcase
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

FILE: hdl/indexed_list_engine_unit.sv
// Top level of the indexed list engine: sequencer, result register and the cell chain.
// Depends on ile_pkg, ile_ifs (ile_req_if, ile_rsp_if) and ile_cell.
module indexed_list_engine_unit #(
    parameter int CAPACITY     = 64,
    parameter int ELEMENT_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ile_pkg::CFG_BITS-1:0]   cfg_wdata,
    ile_req_if.sink                        req,
    ile_rsp_if.source                      rsp
);
    // Bounded ordered list of up to CAPACITY entries held in a chain of cells, one entry
    // per cell. Each request word is one of: insert at a position (later entries move one
    // place down), read at a position, find the first position of a value, remove the
    // first entry equal to a value, or remove at a position. Every request gives exactly
    // one response word with a status, the value, the position and the new count.
    // A request runs in steps: on the accept edge every cell compares its entry (or its
    // index) against the request and latches a hit bit; the next cycle isolates the
    // first hit across the chain with one wide subtract; the update step resolves the
    // status, loads the response register and moves the cells one place left or right
    // in parallel. The response register lets the next request be accepted while a
    // response still waits; the update step waits only if that register is still full.
    // cfg_wdata sets the entry limit; zero (or anything above CAPACITY) means CAPACITY.
    // Write it only while no request is in flight.
    import ile_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int LW = (CW > POS_BITS) ? CW : POS_BITS;
    localparam int VW = (ELEMENT_BITS > VALUE_BITS) ? ELEMENT_BITS : VALUE_BITS;
    localparam logic [CAPACITY-1:0] ONE = {{(CAPACITY-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEL,
        S_ACT
    } state_t;

    state_t                   state_reg;
    logic [CFG_BITS-1:0]      max_reg;
    logic [CW-1:0]            count_reg;
    logic [MODE_BITS-1:0]     mode_reg;
    logic [POS_BITS-1:0]      pos_reg;
    logic [ELEMENT_BITS-1:0]  elem_reg;
    logic [CAPACITY-1:0]      first_reg;
    logic [CAPACITY-1:0]      after_reg;
    logic                     any_hit_reg;

    logic                     out_valid_reg;
    logic [STATUS_BITS-1:0]   out_status_reg;
    logic [VALUE_BITS-1:0]    out_value_reg;
    logic [POS_BITS-1:0]      out_pos_reg;
    logic [POS_BITS-1:0]      out_count_reg;

    logic [ELEMENT_BITS-1:0]  req_elem;
    probe_t                   probe;
    logic                     accept;
    logic                     act_fire;
    logic [CAPACITY-1:0]      hits;
    logic [ELEMENT_BITS-1:0]  cell_value [CAPACITY];
    cell_cmd_t                cell_cmd   [CAPACITY];
    logic [ELEMENT_BITS-1:0]  cell_elem;

    logic [LW-1:0]            limit;
    logic [ELEMENT_BITS-1:0]  sel_value;
    logic [IW-1:0]            sel_index;
    logic [STATUS_BITS-1:0]   status_next;
    logic [VW-1:0]            value_next;
    logic [LW-1:0]            pos_next;
    logic [CW-1:0]            count_next;
    logic                     do_insert;
    logic                     do_remove;

    // Request side: take a word only when the sequencer is free
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign req_elem  = ELEMENT_BITS'(req.element);

    // Cells compare against the live request on the accept edge
    assign probe.by_value = (req.mode == MODE_FIND) || (req.mode == MODE_REMOVE_VAL);
    assign probe.position = req.position;
    assign cell_elem      = (state_reg == S_IDLE) ? req_elem : elem_reg;

    // Advance the update step only if the response register is free or draining
    assign act_fire = (state_reg == S_ACT) && (!out_valid_reg || rsp.ready);

    // Effective entry limit
    always_comb
    begin
        if ((max_reg == '0) || (LW'(max_reg) > LW'(CAPACITY)))
            limit = LW'(CAPACITY);
        else
            limit = LW'(max_reg);
    end

    // Gather the value and index of the first hit (first_reg is one-hot or zero)
    always_comb
    begin
        sel_value = '0;
        sel_index = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_reg[i])
            begin
                sel_value = sel_value | cell_value[i];
                sel_index = sel_index | IW'(i);
            end
        end
    end

    // Resolve status and result of the pending operation
    always_comb
    begin
        status_next = ST_OK;
        value_next  = '0;
        pos_next    = '0;
        count_next  = count_reg;
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        case (mode_reg)
            MODE_INSERT:
            begin
                if (LW'(count_reg) >= limit)
                    status_next = ST_FULL;
                else if (LW'(pos_reg) > LW'(count_reg))
                    status_next = ST_BADPOS;
                else
                begin
                    do_insert  = 1'b1;
                    value_next = VW'(elem_reg);
                    pos_next   = LW'(pos_reg);
                    count_next = count_reg + CW'(1);
                end
            end
            MODE_READ_AT, MODE_REMOVE_AT:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else if (LW'(pos_reg) >= LW'(count_reg))
                    status_next = ST_BADPOS;
                else
                begin
                    value_next = VW'(sel_value);
                    pos_next   = LW'(pos_reg);
                    if (mode_reg == MODE_REMOVE_AT)
                    begin
                        do_remove  = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            MODE_FIND, MODE_REMOVE_VAL:
            begin
                if (!any_hit_reg)
                    status_next = ST_NOTFOUND;
                else
                begin
                    value_next = VW'(sel_value);
                    pos_next   = LW'(sel_index);
                    if (mode_reg == MODE_REMOVE_VAL)
                    begin
                        do_remove  = 1'b1;
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default:
                status_next = ST_BADPOS;
        endcase
    end

    // Per-cell commands: insert opens a gap at the first hit, remove closes it
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (act_fire && do_insert)
            begin
                if (first_reg[i])
                    cell_cmd[i] = CMD_LOAD;
                else if (after_reg[i])
                    cell_cmd[i] = CMD_TAKE_LEFT;
                else
                    cell_cmd[i] = CMD_HOLD;
            end
            else if (act_fire && do_remove && (first_reg[i] || after_reg[i]))
                cell_cmd[i] = CMD_TAKE_RIGHT;
            else
                cell_cmd[i] = CMD_HOLD;
        end
    end

    // The cell chain
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [ELEMENT_BITS-1:0] left_value;
        logic [ELEMENT_BITS-1:0] right_value;

        if (g == 0)
        begin : g_head
            assign left_value = '0;
        end
        else
        begin : g_left
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_value = '0;
        end
        else
        begin : g_right
            assign right_value = cell_value[g+1];
        end

        ile_cell #(
            .IDX          (g),
            .ELEMENT_BITS (ELEMENT_BITS),
            .CW           (CW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .capture     (accept),
            .probe       (probe),
            .elem        (cell_elem),
            .count       (count_reg),
            .cmd         (cell_cmd[g]),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[g]),
            .hit         (hits[g])
        );
    end

    // Sequencer, operation registers and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_reg        <= '0;
            count_reg      <= '0;
            mode_reg       <= '0;
            pos_reg        <= '0;
            elem_reg       <= '0;
            first_reg      <= '0;
            after_reg      <= '0;
            any_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_value_reg  <= '0;
            out_pos_reg    <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
                max_reg <= cfg_wdata;

            // Load a new response on the update step, else drop the one just taken
            if (act_fire)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg  <= req.mode;
                        pos_reg   <= req.position;
                        elem_reg  <= req_elem;
                        state_reg <= S_SEL;
                    end
                end
                S_SEL:
                begin
                    // Isolate the lowest hit and mark every cell above it
                    first_reg   <= hits & (~hits + ONE);
                    after_reg   <= ~(hits ^ (hits - ONE));
                    any_hit_reg <= |hits;
                    state_reg   <= S_ACT;
                end
                S_ACT:
                begin
                    if (act_fire)
                    begin
                        count_reg      <= count_next;
                        out_status_reg <= status_next;
                        out_value_reg  <= value_next[VALUE_BITS-1:0];
                        out_pos_reg    <= pos_next[POS_BITS-1:0];
                        out_count_reg  <= POS_BITS'(LW'(count_next));
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.value_out    = out_value_reg;
    assign rsp.position_out = out_pos_reg;
    assign rsp.count_out    = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(count_reg) <= LW'(CAPACITY))
        else $error("entry count above capacity");

    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACT) |-> $onehot0(first_reg))
        else $error("more than one first hit");

    a_first_after_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACT) |-> ((first_reg & after_reg) == '0))
        else $error("first hit overlaps shift mask");

    a_count_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        !act_fire |=> $stable(count_reg))
        else $error("count changed outside the update step");

    a_update_gives_response: assert property (@(posedge clk) disable iff (!rst_n)
        act_fire |=> out_valid_reg)
        else $error("update step lost its response");
`endif

endmodule
